// ===== design/csgc_pkg.sv =====
// Shared constants and types for the character-set group classifier.
`timescale 1ns / 1ps

package csgc_pkg;

    localparam int MAX_GROUPS = 256;
    localparam int SET_WORDS  = 4;
    localparam int WORD_W     = 64;
    localparam int WSEL_W     = $clog2(SET_WORDS);
    localparam int SLOT_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CNT_W      = $clog2(MAX_GROUPS + 1);
    localparam int ADDR_W     = SLOT_W + WSEL_W;
    localparam int KEY_DEPTH  = MAX_GROUPS * SET_WORDS;
    localparam int IDX_W      = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        logic       end_of_string;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0] group_index;
        logic             is_new_group;
        logic             table_full;
    } t_out_item;

    typedef logic [SET_WORDS-1:0][WORD_W-1:0] t_char_set;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic      ready;
        logic      done;
        logic      clear_set;
        t_out_item res;
    } t_ctrl_stat;

endpackage

// ===== design/char_set_group_classifier.sv =====
// Top level of the character-set group classifier: set register, sequencer, key memory.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                  Payload
//  input     in         i_in_valid / o_in_stall    i_in_item  (t_in_item)
//  result    out        o_out_valid / i_out_stall  o_out_item (t_out_item)
//
// An item without end_of_string only updates the 256-bit set register. After an
// end item is taken, the lookup keeps the block busy while it scans the stored
// groups. The single read port of the key memory yields one 64-bit word per
// cycle, and the last compare comes in the cycle after its read. With no stored
// groups the lookup is skipped. A new key is then written into the key memory
// word by word, and the result moves to the output register once it is free.
// The lookup stops at the first matching group.
// Reset is synchronous and active low; it clears the set and the group count.
// The key memory needs no clearing, because only stored groups are ever read.
// A stalled result waits in the output register; new items are held off only
// while the sequencer is busy or its result cannot yet be moved out.

module char_set_group_classifier import csgc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_char_set         r_set;
    logic              r_out_valid;
    t_out_item         r_out;
    t_ram_req          w_ram;
    t_ctrl_stat        w_stat;
    logic [WORD_W-1:0] w_rdata;
    logic              w_accept;
    logic              w_out_free;

    // An input transfer happens only while the sequencer is idle.
    assign o_in_stall = !w_stat.ready;
    assign w_accept   = i_in_valid && w_stat.ready;

    // The output register can take a new result when it is empty or draining.
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Character-set register. The character on an end item still belongs to
    // the string; the set is cleared once the result leaves the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set <= '0;
        end else if (w_stat.clear_set) begin
            r_set <= '0;
        end else if (w_accept && i_in_item.ch_valid) begin
            r_set[i_in_item.ch[7:6]][i_in_item.ch[5:0]] <= 1'b1;
        end
    end

    csgc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_in_item),
        .i_accept   (w_accept),
        .i_out_free (w_out_free),
        .i_set      (r_set),
        .i_rdata    (w_rdata),
        .o_ram      (w_ram),
        .o_stat     (w_stat)
    );

    csgc_key_ram u_key_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram),
        .o_rdata (w_rdata)
    );

    // Output register that decouples the result transfer from the sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done && w_out_free) begin
            r_out <= w_stat.res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== design/csgc_key_ram.sv =====
// Key memory: one 64-bit word per row, one write and one registered read per cycle.
`timescale 1ns / 1ps

module csgc_key_ram import csgc_pkg::*; (
    input  logic              i_clk,
    input  t_ram_req          i_req,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [KEY_DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/csgc_ctrl.sv =====
// Sequencer that scans the key memory word by word through one shared comparator.
`timescale 1ns / 1ps

module csgc_ctrl import csgc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_item,
    input  logic              i_accept,
    input  logic              i_out_free,
    input  t_char_set         i_set,
    input  logic [WORD_W-1:0] i_rdata,
    output t_ram_req          o_ram,
    output t_ctrl_stat        o_stat
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_STORE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state            r_state,    n_state;
    logic [SLOT_W-1:0] r_slot,     n_slot;
    logic [WSEL_W-1:0] r_word,     n_word;
    logic              r_issue,    n_issue;
    logic              r_cmp_v,    n_cmp_v;
    logic [SLOT_W-1:0] r_cmp_slot, n_cmp_slot;
    logic [WSEL_W-1:0] r_cmp_word, n_cmp_word;
    logic              r_cmp_last, n_cmp_last;
    logic              r_ok,       n_ok;
    logic [CNT_W-1:0]  r_count,    n_count;
    t_out_item         r_res,      n_res;

    logic w_issue_last;
    logic w_eq;
    logic w_ok_now;
    logic w_room;

    localparam logic [WSEL_W-1:0] LastWord = WSEL_W'(SET_WORDS - 1);

    // The slot being read is the last stored one.
    assign w_issue_last = ((CNT_W + 1)'(r_slot) + (CNT_W + 1)'(1)) == (CNT_W + 1)'(r_count);
    // The shared comparator: one stored word against the matching word of the set.
    assign w_eq     = (i_rdata == i_set[r_cmp_word]);
    assign w_ok_now = w_eq & ((r_cmp_word == '0) | r_ok);
    assign w_room   = (r_count != CNT_W'(MAX_GROUPS));

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_word     = r_word;
        n_issue    = r_issue;
        n_cmp_v    = r_cmp_v;
        n_cmp_slot = r_cmp_slot;
        n_cmp_word = r_cmp_word;
        n_cmp_last = r_cmp_last;
        n_ok       = r_ok;
        n_count    = r_count;
        n_res      = r_res;

        o_ram       = '0;
        o_ram.re    = r_issue;
        o_ram.raddr = {r_slot, r_word};

        o_stat           = '0;
        o_stat.ready     = (r_state == S_IDLE);
        o_stat.res       = r_res;

        unique case (r_state)
            S_IDLE: begin
                if (i_accept && i_item.end_of_string) begin
                    n_slot = '0;
                    n_word = '0;
                    if (r_count == '0) begin
                        n_state = S_STORE;
                        n_res   = '{group_index: '0, is_new_group: 1'b1, table_full: 1'b0};
                    end else begin
                        n_state = S_SCAN;
                        n_issue = 1'b1;
                        n_cmp_v = 1'b0;
                        n_ok    = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // Read stage.
                n_cmp_v = r_issue;
                if (r_issue) begin
                    n_cmp_slot = r_slot;
                    n_cmp_word = r_word;
                    n_cmp_last = w_issue_last;
                    n_word     = r_word + 1'b1;
                    if (r_word == LastWord) begin
                        if (w_issue_last) begin
                            n_issue = 1'b0;
                        end else begin
                            n_slot = r_slot + 1'b1;
                        end
                    end
                end
                // Compare stage.
                if (r_cmp_v) begin
                    n_ok = w_ok_now;
                    if (r_cmp_word == LastWord) begin
                        if (w_ok_now) begin
                            n_state = S_DONE;
                            n_issue = 1'b0;
                            n_cmp_v = 1'b0;
                            n_res   = '{group_index: IDX_W'(r_cmp_slot),
                                        is_new_group: 1'b0, table_full: 1'b0};
                        end else if (r_cmp_last) begin
                            n_issue = 1'b0;
                            n_cmp_v = 1'b0;
                            if (w_room) begin
                                n_state = S_STORE;
                                n_slot  = SLOT_W'(r_count);
                                n_word  = '0;
                                n_res   = '{group_index: IDX_W'(r_count),
                                            is_new_group: 1'b1, table_full: 1'b0};
                            end else begin
                                n_state = S_DONE;
                                n_res   = '{group_index: '0,
                                            is_new_group: 1'b1, table_full: 1'b1};
                            end
                        end
                    end
                end
            end
            S_STORE: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = {r_slot, r_word};
                o_ram.wdata = i_set[r_word];
                n_word      = r_word + 1'b1;
                if (r_word == LastWord) begin
                    n_count = r_count + 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_stat.done = 1'b1;
                if (i_out_free) begin
                    o_stat.clear_set = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_cmp_v <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_issue <= n_issue;
            r_cmp_v <= n_cmp_v;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot     <= n_slot;
        r_word     <= n_word;
        r_cmp_slot <= n_cmp_slot;
        r_cmp_word <= n_cmp_word;
        r_cmp_last <= n_cmp_last;
        r_ok       <= n_ok;
        r_res      <= n_res;
    end

    // The group count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_GROUPS))
        else $error("group count beyond table size");

    // Only stored slots are read during a scan.
    a_read_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.re |-> ((CNT_W + 1)'(r_slot) < (CNT_W + 1)'(r_count)))
        else $error("read of a slot that was never stored");

    // Writes land on the next free slot only.
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.we |-> ((CNT_W + 1)'(r_slot) == (CNT_W + 1)'(r_count)) && w_room)
        else $error("key write outside the next free slot");

    // A full table always reports a new set with group zero.
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.done && o_stat.res.table_full) |->
            (o_stat.res.is_new_group && (o_stat.res.group_index == '0)))
        else $error("table-full result with wrong fields");

    // A finished item completes the count update before the result is shown.
    a_store_then_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram.we && (r_word == LastWord)) |=> (r_state == S_DONE))
        else $error("store did not finish into the result state");

endmodule
